// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the culling block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define AFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define AFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/afc_pkg.sv
// Types and constants shared by the box-versus-frustum culling block.
package afc_pkg;

    localparam int COORD_W      = 32;  // Q16.16 coordinate and matrix entry
    localparam int COEF_W       = 33;  // plane coefficient: sum of two entries
    localparam int HEIGHT_W     = 12;
    localparam int EXT_Y_W      = 13;  // max(height, 1) + 4
    localparam int SUM_W        = 68;  // Q32.32 plane distance, cannot overflow
    localparam int NUM_PLANES   = 6;
    localparam int MAT_ROWS     = 4;
    localparam int MAT_COLS     = 4;
    localparam int NUM_MAT_REGS = 8;
    localparam int MAT_IDX_W    = 3;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int EXT_SHIFT    = 15;  // extents are multiples of half a cell
    localparam int W_SHIFT      = 16;  // Q16.16 to Q32.32

    // Reset contents of the matrix registers: the identity matrix.
    localparam logic [CFG_DATA_W-1:0] MAT_RESET [NUM_MAT_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    // One clip plane with the magnitudes that the radius term needs.
    typedef struct packed {
        logic signed [COEF_W-1:0] nx;
        logic signed [COEF_W-1:0] ny;
        logic signed [COEF_W-1:0] nz;
        logic signed [COEF_W-1:0] w;
        logic        [COEF_W-1:0] abs_y;
        logic        [COEF_W:0]   abs_xz;
    } afc_plane_t;

    // Load enables for the two pipeline stages inside each plane unit.
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } afc_adv_t;

endpackage

// File: rtl/afc_plane_test.sv
// Distance of one box from one clip plane: product stage, sum stage, sign test.
module afc_plane_test #(
    parameter int PAGE_SIZE = 32
) (
    input  logic                                clk,
    input  afc_pkg::afc_adv_t                   adv,
    input  afc_pkg::afc_plane_t                 plane,
    input  logic signed [afc_pkg::COORD_W-1:0]  center_x,
    input  logic signed [afc_pkg::COORD_W-1:0]  center_y,
    input  logic signed [afc_pkg::COORD_W-1:0]  center_z,
    input  logic        [afc_pkg::EXT_Y_W-1:0]  ext_y_factor,
    output logic                                inside_ok
);
    import afc_pkg::*;

    localparam int EXT_XZ   = PAGE_SIZE + 4;
    localparam int EXT_XZ_W = $clog2(EXT_XZ + 1);
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int RAD_Y_W  = EXT_Y_W + COEF_W;
    localparam int RAD_XZ_W = EXT_XZ_W + COEF_W + 1;
    localparam int RAD_W    = ((RAD_Y_W > RAD_XZ_W) ? RAD_Y_W : RAD_XZ_W) + 1;
    localparam logic [EXT_XZ_W-1:0] EXT_XZ_F = EXT_XZ_W'(EXT_XZ);

    logic signed [PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_reg, prod_y_next;
    logic signed [PROD_W-1:0]  prod_z_reg, prod_z_next;
    logic        [RAD_Y_W-1:0] rad_y_reg, rad_y_next;
    logic        [RAD_XZ_W-1:0] rad_xz_reg, rad_xz_next;
    logic signed [COEF_W-1:0]  w_reg, w_next;
    logic        [RAD_W-1:0]   rad_sum;
    logic signed [SUM_W-1:0]   sum_a_reg, sum_a_next;
    logic signed [SUM_W-1:0]   sum_b_reg, sum_b_next;
    logic signed [SUM_W-1:0]   total;

    // The extents are (factor) half cells, so the radius is scaled by 2^15 later.
    always_comb
    begin
        prod_x_next = $signed(plane.nx) * center_x;
        prod_y_next = $signed(plane.ny) * center_y;
        prod_z_next = $signed(plane.nz) * center_z;
        rad_y_next  = RAD_Y_W'(ext_y_factor) * RAD_Y_W'(plane.abs_y);
        rad_xz_next = RAD_XZ_W'(EXT_XZ_F) * RAD_XZ_W'(plane.abs_xz);
        w_next      = plane.w;
    end

    always_comb
    begin
        rad_sum    = RAD_W'(rad_y_reg) + RAD_W'(rad_xz_reg);
        sum_a_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg);
        sum_b_next = $signed(SUM_W'({rad_sum, {EXT_SHIFT{1'b0}}}))
                   + (SUM_W'(w_reg) <<< W_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_prod)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            rad_y_reg  <= rad_y_next;
            rad_xz_reg <= rad_xz_next;
            w_reg      <= w_next;
        end
        if (adv.load_sum)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // A distance of exactly zero still counts as inside.
    assign total     = sum_a_reg + sum_b_reg;
    assign inside_ok = ~total[SUM_W-1];

endmodule

// File: rtl/aabb_frustum_cull.sv
// Box-versus-frustum culling: one box per clock while the output is not
// stalled. The path is a five-register pipeline (input, extent prep, plane
// products, partial sums, result), so the sustained rate is one box per
// cycle; a stalled result holds the pipeline. The six clip planes are rebuilt
// from the matrix registers into plane registers in the cycle after a
// configuration write.
module aabb_frustum_cull #(
    parameter int PAGE_SIZE = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [afc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [afc_pkg::COORD_W-1:0]    center_x,
    input  logic signed [afc_pkg::COORD_W-1:0]    center_y,
    input  logic signed [afc_pkg::COORD_W-1:0]    center_z,
    input  logic        [afc_pkg::HEIGHT_W-1:0]   segment_height,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  visible
);
    import afc_pkg::*;

    localparam int NUM_STAGES = 4;

    logic [CFG_DATA_W-1:0]       mat_reg [NUM_MAT_REGS];
    afc_plane_t                  plane_reg [NUM_PLANES];
    afc_plane_t                  plane_next [NUM_PLANES];

    logic [NUM_STAGES-1:0]       valid_reg;
    logic [NUM_STAGES:0]         ready;
    logic                        out_valid_reg;
    logic                        visible_reg;
    logic                        visible_next;

    logic signed [COORD_W-1:0]   cx0_reg, cy0_reg, cz0_reg;
    logic [HEIGHT_W-1:0]         height0_reg;
    logic signed [COORD_W-1:0]   cx1_reg, cy1_reg, cz1_reg;
    logic [EXT_Y_W-1:0]          ext_y1_reg, ext_y1_next;
    afc_adv_t                    adv;
    logic [NUM_PLANES-1:0]       plane_ok;

    // Configuration registers; writes beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MAT_REGS; i++)
            begin
                mat_reg[i] <= MAT_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_MAT_REGS)))
        begin
            mat_reg[cfg_index[MAT_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // Planes are row 3 plus or minus rows 0, 1 and 2, in that order.
    always_comb
    begin
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COEF_W-1:0]  n   [MAT_COLS];
        logic        [COEF_W-1:0]  mag [MAT_COLS];
        int                        row;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            row = p >> 1;
            for (int k = 0; k < MAT_COLS; k++)
            begin
                a = $signed(mat_reg[MAT_IDX_W'(((MAT_ROWS - 1) << 1) + (k >> 1))]
                            [(k & 1) * COORD_W +: COORD_W]);
                b = $signed(mat_reg[MAT_IDX_W'((row << 1) + (k >> 1))]
                            [(k & 1) * COORD_W +: COORD_W]);
                if ((p & 1) != 0)
                begin
                    n[k] = COEF_W'(a) - COEF_W'(b);
                end
                else
                begin
                    n[k] = COEF_W'(a) + COEF_W'(b);
                end
                mag[k] = n[k][COEF_W-1] ? unsigned'(-n[k]) : unsigned'(n[k]);
            end
            plane_next[p].nx     = n[0];
            plane_next[p].ny     = n[1];
            plane_next[p].nz     = n[2];
            plane_next[p].w      = n[3];
            plane_next[p].abs_y  = mag[1];
            plane_next[p].abs_xz = (COEF_W + 1)'(mag[0]) + (COEF_W + 1)'(mag[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    // A stage may load when it is empty or its content moves on in this cycle.
    always_comb
    begin
        ready[NUM_STAGES] = ~out_valid_reg | ~out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            ready[k] = ~valid_reg[k] | ready[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
            if (ready[NUM_STAGES])
            begin
                out_valid_reg <= valid_reg[NUM_STAGES - 1];
            end
        end
    end

    // A zero height is treated as one cell; the factor counts half cells.
    always_comb
    begin
        if (height0_reg == '0)
        begin
            ext_y1_next = EXT_Y_W'(5);
        end
        else
        begin
            ext_y1_next = EXT_Y_W'(height0_reg) + EXT_Y_W'(4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready[0])
        begin
            cx0_reg     <= center_x;
            cy0_reg     <= center_y;
            cz0_reg     <= center_z;
            height0_reg <= segment_height;
        end
        if (valid_reg[0] && ready[1])
        begin
            cx1_reg    <= cx0_reg;
            cy1_reg    <= cy0_reg;
            cz1_reg    <= cz0_reg;
            ext_y1_reg <= ext_y1_next;
        end
        if (valid_reg[NUM_STAGES - 1] && ready[NUM_STAGES])
        begin
            visible_reg <= visible_next;
        end
    end

    assign adv.load_prod = valid_reg[1] & ready[2];
    assign adv.load_sum  = valid_reg[2] & ready[3];

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        afc_plane_test #(
            .PAGE_SIZE    (PAGE_SIZE)
        ) u_plane (
            .clk          (clk),
            .adv          (adv),
            .plane        (plane_reg[p]),
            .center_x     (cx1_reg),
            .center_y     (cy1_reg),
            .center_z     (cz1_reg),
            .ext_y_factor (ext_y1_reg),
            .inside_ok    (plane_ok[p])
        );
    end

    assign visible_next = &plane_ok;
    assign in_stall     = ~ready[0];
    assign out_valid    = out_valid_reg;
    assign visible      = visible_reg;

endmodule

// File: rtl/afc_checker.sv
// Port-level checker for the culling block and the bind that attaches it.
`include "assert_macros.svh"

module afc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic visible
);

    `AFC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    `AFC_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(visible), "stalled result changed")

    // The input side can only stall when the whole pipeline is blocked at the output.
    `AFC_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without a blocked result")

    // A transaction that goes in comes out as a result when the output is not stalled on its way.
    `AFC_ASSERT(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "result missing after pipeline latency")

    `AFC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid && !in_stall, "not idle during reset")

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible)
);

// File: sim/tb_top.sv
// Self-checking testbench for the box-versus-frustum culling block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int PAGE_SIZE    = 32;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_WAIT  = 4;
    localparam int NUM_PHASES   = 25;
    localparam int PHASE_BOXES  = 60;
    localparam int PAUSE_PHASE  = 10;
    localparam int NUM_DIRECTED = 21;

    typedef enum int {
        MAT_ZERO,
        MAT_MAX,
        MAT_MIN,
        MAT_ONES,
        MAT_NEAR_ID,
        MAT_WIDE,
        MAT_NARROW
    } mat_kind_e;

    typedef enum int {
        COORD_NEAR,
        COORD_FULL,
        COORD_EXTREME
    } coord_mode_e;

    typedef struct packed {
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        logic [HEIGHT_W-1:0] h;
        logic                vis;
    } box_t;

    typedef struct packed {
        logic                typed;
        logic                vis;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cz;
        logic [HEIGHT_W-1:0] h;
    } dir_row_t;

    // Rows with a typed result run on the identity matrix that reset leaves.
    // Edges of the box sit at 19 cells in x and z, and at max(h,1)/2 + 3 in y.
    localparam dir_row_t DIRECTED_BOXES [NUM_DIRECTED] = '{
        '{1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b1, 32'h0013_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b0, 32'h0013_0001, 32'h0000_0000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b1, 32'hFFED_0000, 32'h0000_0000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b0, 32'hFFEC_FFFF, 32'h0000_0000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0013_0000, 12'd0},
        '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0013_0001, 12'd0},
        '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFEC_FFFF, 12'd0},
        '{1'b1, 1'b1, 32'h0000_0000, 32'h0003_8000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b0, 32'h0000_0000, 32'h0003_8001, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b1, 32'h0000_0000, 32'hFFFC_8000, 32'h0000_0000, 12'd0},
        '{1'b1, 1'b0, 32'h0000_0000, 32'h0003_8001, 32'h0000_0000, 12'd1},
        '{1'b1, 1'b1, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000, 12'd2},
        '{1'b1, 1'b1, 32'h0000_0000, 32'h0802_8000, 32'h0000_0000, 12'd4095},
        '{1'b1, 1'b0, 32'h0000_0000, 32'h0802_8001, 32'h0000_0000, 12'd4095},
        '{1'b1, 1'b1, 32'h0000_0000, 32'hF7FD_8000, 32'h0000_0000, 12'd4095},
        '{1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd4095},
        '{1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'd0},
        '{1'b1, 1'b1, 32'h0013_0000, 32'h0003_8000, 32'hFFED_0000, 12'd0},
        '{1'b0, 1'b0, 32'h000A_8000, 32'hFFF0_0000, 32'h0010_0000, 12'hABC},
        '{1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 12'h555}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic        [CFG_IDX_W-1:0]  cfg_index;
    logic        [CFG_DATA_W-1:0] cfg_wdata;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [COORD_W-1:0]    center_x;
    logic signed [COORD_W-1:0]    center_y;
    logic signed [COORD_W-1:0]    center_z;
    logic        [HEIGHT_W-1:0]   segment_height;
    logic                         out_valid;
    logic                         out_stall;
    logic                         visible;

    logic [CFG_DATA_W-1:0] mat_reg [NUM_MAT_REGS];
    box_t                  pending_boxes [$];

    int  errors        = 0;
    int  boxes_sent    = 0;
    int  results_seen  = 0;
    int  culled_seen   = 0;
    int  settings_used = 0;
    int  drain_pauses  = 0;
    int  idle_cycles   = 0;
    bit  no_gaps       = 1'b0;

    aabb_frustum_cull #(
        .PAGE_SIZE(PAGE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .center_x(center_x),
        .center_y(center_y),
        .center_z(center_z),
        .segment_height(segment_height),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .visible(visible)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [COORD_W-1:0] plane_matrix_entry(int r, int c);
        logic [CFG_DATA_W-1:0] packed_pair;
        packed_pair = mat_reg[r * 2 + c / 2];
        return (c % 2) ? packed_pair[63:32] : packed_pair[31:0];
    endfunction

    // Exact Q32.32 signed distance of each of the six planes; wide enough for any input.
    function automatic bit box_visible(input logic signed [COORD_W-1:0] cx,
                                       input logic signed [COORD_W-1:0] cy,
                                       input logic signed [COORD_W-1:0] cz,
                                       input logic [HEIGHT_W-1:0] h);
        logic signed [127:0] centre [3];
        logic signed [127:0] extent [3];
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] n;
        logic signed [127:0] n_abs;
        logic signed [127:0] plane_sum;
        logic [HEIGHT_W-1:0] hh;
        int                  p;
        int                  k;
        bit                  vis;
        vis = 1'b1;
        hh = (h == '0) ? 12'd1 : h;
        centre[0] = cx;
        centre[1] = cy;
        centre[2] = cz;
        extent[0] = 128'(PAGE_SIZE) * 128'd32768 + 128'd131072;
        extent[1] = 128'(hh) * 128'd32768 + 128'd131072;
        extent[2] = extent[0];
        for (p = 0; p < NUM_PLANES; p++)
        begin
            plane_sum = '0;
            for (k = 0; k < MAT_COLS; k++)
            begin
                a = plane_matrix_entry(MAT_ROWS - 1, k);
                b = plane_matrix_entry(p / 2, k);
                n = (p % 2) ? a - b : a + b;
                n_abs = (n < 0) ? -n : n;
                if (k < 3)
                    plane_sum = plane_sum + n * centre[k] + extent[k] * n_abs;
                else
                    plane_sum = plane_sum + n * 128'sd65536;
            end
            if (plane_sum < 0)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(coord_mode_e mode);
        int sel;
        case (mode)
            COORD_NEAR:
                return $urandom_range(0, 2 ** 23) - 2 ** 22;
            COORD_FULL:
                return $urandom;
            default:
            begin
                sel = $urandom_range(0, 3);
                case (sel)
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] make_entry(mat_kind_e kind, int r, int c);
        int v;
        case (kind)
            MAT_ZERO:   return 32'h0000_0000;
            MAT_MAX:    return 32'h7FFF_FFFF;
            MAT_MIN:    return 32'h8000_0000;
            MAT_ONES:   return 32'hFFFF_FFFF;
            MAT_WIDE:   return $urandom;
            MAT_NARROW: return $urandom_range(0, 2 ** 19) - 2 ** 18;
            default:
            begin
                // Scaled identity with a far w, slightly skewed, so that
                // boxes near the origin land on both sides of the planes.
                if (r == MAT_ROWS - 1 && c == MAT_COLS - 1)
                    v = $urandom_range(2 ** 16, 2 ** 22);
                else if (r == c)
                    v = $urandom_range(2 ** 15, 2 ** 18);
                else
                    v = $urandom_range(0, 8192) - 4096;
                if ($urandom_range(0, 7) == 0)
                    v = -v;
                return v;
            end
        endcase
    endfunction

    task automatic send_box(input box_t b, input bit typed);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        center_x       <= b.cx;
        center_y       <= b.cy;
        center_z       <= b.cz;
        segment_height <= b.h;
        do
            @(posedge clk);
        while (in_stall);
        if (!typed)
            b.vis = box_visible(b.cx, b.cy, b.cz, b.h);
        pending_boxes = {pending_boxes, b};
        boxes_sent++;
    endtask

    // Stops the sender until every box in flight has come back, then lets the
    // pipeline and the plane registers settle.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        drain_pauses++;
    endtask

    task automatic program_matrix(mat_kind_e kind, bit add_stray);
        int                    i;
        logic [CFG_DATA_W-1:0] value;
        if (add_stray)
        begin
            // Indexes past the last matrix register must leave the matrix alone.
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(NUM_MAT_REGS + $urandom_range(0, NUM_MAT_REGS - 1));
            cfg_wdata <= {$urandom, $urandom};
            @(posedge clk);
        end
        for (i = 0; i < NUM_MAT_REGS; i++)
        begin
            value = {make_entry(kind, i / 2, (i % 2) * 2 + 1),
                     make_entry(kind, i / 2, (i % 2) * 2)};
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= value;
            mat_reg[i] = value;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        repeat (SETTLE_WAIT) @(posedge clk);
        settings_used++;
    endtask

    // Result side: random stalls, mostly short, with some long ones and quiet stretches.
    initial
    begin
        int sel;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                if (sel < 80)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (sel < 96)
                    repeat ($urandom_range(4, 12)) @(posedge clk);
                else
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        box_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_boxes.size() == 0)
            begin
                errors++;
                $display("%0t: result with no box in flight, visible=%0b", $time, visible);
            end
            else
            begin
                head = pending_boxes.pop_front();
                results_seen++;
                if (!head.vis)
                    culled_seen++;
                if (visible !== head.vis)
                begin
                    errors++;
                    $display("%0t: visible mismatch, expected %0b actual %0b (box %h %h %h h=%0d)",
                             $time, head.vis, visible, head.cx, head.cy, head.cz, head.h);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_boxes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int          i;
        int          phase;
        int          n;
        int          sel;
        mat_kind_e   kind;
        coord_mode_e mode;
        box_t        b;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        center_x       = '0;
        center_y       = '0;
        center_z       = '0;
        segment_height = '0;
        for (i = 0; i < NUM_MAT_REGS; i++)
            mat_reg[i] = MAT_RESET[i];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            b.cx  = DIRECTED_BOXES[i].cx;
            b.cy  = DIRECTED_BOXES[i].cy;
            b.cz  = DIRECTED_BOXES[i].cz;
            b.h   = DIRECTED_BOXES[i].h;
            b.vis = DIRECTED_BOXES[i].vis;
            send_box(b, DIRECTED_BOXES[i].typed);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipeline();
            // The first settings walk the extreme matrices, the rest are random.
            if (phase < 4)
                kind = mat_kind_e'(phase);
            else
            begin
                sel = $urandom_range(0, 3);
                kind = (sel < 2) ? MAT_NEAR_ID : ((sel == 2) ? MAT_WIDE : MAT_NARROW);
            end
            program_matrix(kind, phase == 0 || $urandom_range(0, 1) == 1);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_BOXES; n++)
            begin
                if (phase == PAUSE_PHASE && n == PHASE_BOXES / 2)
                    drain_pipeline();
                sel = $urandom_range(0, 9);
                mode = (sel < 5) ? COORD_NEAR : ((sel < 9) ? COORD_FULL : COORD_EXTREME);
                b.cx = rand_coord(mode);
                b.cy = rand_coord(mode);
                b.cz = rand_coord(mode);
                sel = $urandom_range(0, 9);
                b.h = (sel == 0) ? 12'd0 : ((sel == 1) ? 12'd4095 : HEIGHT_W'($urandom));
                b.vis = 1'b0;
                send_box(b, 1'b0);
            end
        end

        drain_pipeline();
        if (pending_boxes.size() != 0)
            errors += pending_boxes.size();
        $display("Sent %0d boxes (%0d directed) over %0d matrix settings, %0d drain pauses.",
                 boxes_sent, NUM_DIRECTED, settings_used + 1, drain_pauses);
        $display("Checked %0d results: %0d visible, %0d culled, %0d errors.",
                 results_seen, results_seen - culled_seen, culled_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: aabb_frustum_cull.f
+incdir+rtl
rtl/afc_pkg.sv
rtl/afc_plane_test.sv
rtl/aabb_frustum_cull.sv
rtl/afc_checker.sv
sim/tb_top.sv
